// File: rtl/core/stdl_pkg.sv
package stdl_pkg;

  localparam int NUM_SLOTS  = 16;
  localparam int DELAY_BITS = 16;
  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam int PTR_W      = 5;
  localparam int MAXRES     = 16;
  localparam int CNT_W      = 5;
  localparam int OPT_W      = 7;
  localparam int EV_W       = 16;

  localparam logic [PTR_W-1:0] NIL = {PTR_W{1'b1}};

  localparam int OPT_PER_BIT   = 4;
  localparam int OPT_LOCK_BIT  = 5;
  localparam int OPT_QUICK_BIT = 6;

  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [DELAY_BITS-1:0] delay_t;

  typedef enum logic [2:0] {
    REQ_ALLOC   = 3'd0,
    REQ_RETURN  = 3'd1,
    REQ_START   = 3'd2,
    REQ_STOP    = 3'd3,
    REQ_RELEASE = 3'd4,
    REQ_RESTART = 3'd5,
    REQ_TICK    = 3'd6,
    REQ_NONE    = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_NOTRUN = 2'd2,
    ST_ZERO   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    K_FREE = 2'd0,
    K_IDLE = 2'd1,
    K_ONE  = 2'd2,
    K_PER  = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    C_NOP,
    C_LOAD,
    C_ALLOC,
    C_RETURN,
    C_REL_LOCK,
    C_RS_PREP,
    C_SET_ST2,
    C_SET_ST3,
    C_FIND_INIT,
    C_FIND_STEP,
    C_UNL_A,
    C_UNL_B,
    C_STOP_FIN,
    C_STORE,
    C_INS_INIT,
    C_INS_WALK,
    C_TK_DEC,
    C_TK_OS,
    C_TK_PINIT,
    C_TK_PER,
    C_OUT_LOAD,
    C_OUT_DONE
  } cmd_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_STOPCHK,
    S_RSCHK,
    S_FIND,
    S_UNL_B,
    S_AFTER_UNL,
    S_INS_INIT,
    S_INS_WALK,
    S_TK_OS,
    S_TK_PINIT,
    S_TK_PER,
    S_RESP,
    S_DRAIN
  } state_t;

  typedef struct packed {
    req_t  req;
    kind_t kind_s;
    logic  d_zero;
    logic  found;
    logic  walk_go;
    logic  os_go;
    logic  cur_ok;
    logic  per_s;
    logic  more;
    logic  out_fire;
  } dp_stat_t;

  function automatic logic ptr_ok(ptr_t p);
    return p < PTR_W'(NUM_SLOTS);
  endfunction

endpackage

// File: rtl/core/stdl_if.sv
interface stdl_in_if import stdl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [2:0]           req_type;
  logic [3:0]           slot;
  logic [15:0]          delay_ticks;
  logic                 keep_delay;
  logic [15:0]          event_value;
  logic [6:0]           options;

  modport source (output valid, req_type, slot, delay_ticks, keep_delay, event_value,
                  options, input ready);
  modport sink   (input valid, req_type, slot, delay_ticks, keep_delay, event_value,
                  options, output ready);
endinterface

interface stdl_out_if import stdl_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  slot_out;
  logic        fired;
  logic [15:0] fired_event;
  logic [3:0]  fired_target;
  logic        fired_quick;
  logic [4:0]  used_count;
  logic        last;

  modport source (output valid, status, slot_out, fired, fired_event, fired_target,
                  fired_quick, used_count, last, input ready);
  modport sink   (input valid, status, slot_out, fired, fired_event, fired_target,
                  fired_quick, used_count, last, output ready);
endinterface

// File: rtl/core/stdl_datapath.sv
module stdl_datapath import stdl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  output dp_stat_t   stat,
  stdl_in_if.sink    in_ch,
  stdl_out_if.source out_ch
);

  ptr_t    link_r   [NUM_SLOTS];
  delay_t  rem_r    [NUM_SLOTS];
  delay_t  per_r    [NUM_SLOTS];
  logic [EV_W-1:0]  ev_r  [NUM_SLOTS];
  logic [OPT_W-1:0] opt_r [NUM_SLOTS];
  kind_t   kind_r   [NUM_SLOTS];

  ptr_t    link_nxt [NUM_SLOTS];
  delay_t  rem_nxt  [NUM_SLOTS];
  delay_t  per_nxt  [NUM_SLOTS];
  logic [EV_W-1:0]  ev_nxt  [NUM_SLOTS];
  logic [OPT_W-1:0] opt_nxt [NUM_SLOTS];
  kind_t   kind_nxt [NUM_SLOTS];

  ptr_t oh_r, ph_r, fh_r, oh_nxt, ph_nxt, fh_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;

  req_t             req_r, req_nxt;
  slot_t            s_r, s_nxt;
  delay_t           d_r, d_nxt;
  logic             keep_r, keep_nxt;
  logic [EV_W-1:0]  evi_r, evi_nxt;
  logic [OPT_W-1:0] opti_r, opti_nxt;
  ptr_t             cur_r, cur_nxt, prv_r, prv_nxt, nx_r, nx_nxt;
  delay_t           acc_r, acc_nxt, rs_r, rs_nxt;
  status_t          st_r, st_nxt;
  slot_t            so_r, so_nxt;
  kind_t            uk_r, uk_nxt;

  slot_t            bslot_r [MAXRES];
  logic [EV_W-1:0]  bev_r   [MAXRES];
  logic [OPT_W-1:0] bopt_r  [MAXRES];
  logic             push;
  slot_t            push_slot;
  logic [CNT_W-1:0] k_r, k_nxt, rd_r, rd_nxt;

  logic             ov_r, ov_nxt;
  status_t          ost_r, ost_nxt;
  slot_t            oslot_r, oslot_nxt;
  logic             ofire_r, ofire_nxt;
  logic [EV_W-1:0]  oev_r, oev_nxt;
  logic [3:0]       otgt_r, otgt_nxt;
  logic             oq_r, oq_nxt;
  logic             olast_r, olast_nxt;

  ptr_t             raddr;
  slot_t            ra;
  ptr_t             link_rd;
  delay_t           rem_rd, per_rd, r_dec;
  logic [EV_W-1:0]  ev_rd;
  logic [OPT_W-1:0] opt_rd;
  logic             k_room;

  always_comb begin
    case (cmd)
      C_ALLOC:                 raddr = fh_r;
      C_FIND_STEP, C_INS_WALK,
      C_TK_PER:                raddr = cur_r;
      C_UNL_B:                 raddr = nx_r;
      C_TK_DEC, C_TK_OS:       raddr = oh_r;
      default:                 raddr = {1'b0, s_r};
    endcase
  end

  assign ra      = raddr[SLOT_W-1:0];
  assign link_rd = link_r[ra];
  assign rem_rd  = rem_r[ra];
  assign per_rd  = per_r[ra];
  assign ev_rd   = ev_r[ra];
  assign opt_rd  = opt_r[ra];
  assign k_room  = k_r < CNT_W'(MAXRES);
  assign r_dec   = (rem_rd != '0) ? rem_rd - 1'b1 : rem_rd;

  assign stat.req      = req_r;
  assign stat.kind_s   = kind_r[s_r];
  assign stat.d_zero   = (d_r == '0);
  assign stat.found    = (cur_r == {1'b0, s_r});
  assign stat.cur_ok   = ptr_ok(cur_r);
  assign stat.walk_go  = ptr_ok(cur_r) && (rem_rd < acc_r);
  assign stat.os_go    = ptr_ok(oh_r) && (rem_rd == '0) && k_room;
  assign stat.per_s    = opt_rd[OPT_PER_BIT];
  assign stat.more     = rd_r < k_r;
  assign stat.out_fire = ov_r && out_ch.ready;

  always_comb begin
    link_nxt = link_r;
    rem_nxt  = rem_r;
    per_nxt  = per_r;
    ev_nxt   = ev_r;
    opt_nxt  = opt_r;
    kind_nxt = kind_r;
    oh_nxt   = oh_r;
    ph_nxt   = ph_r;
    fh_nxt   = fh_r;
    used_nxt = used_r;
    req_nxt  = req_r;
    s_nxt    = s_r;
    d_nxt    = d_r;
    keep_nxt = keep_r;
    evi_nxt  = evi_r;
    opti_nxt = opti_r;
    cur_nxt  = cur_r;
    prv_nxt  = prv_r;
    nx_nxt   = nx_r;
    acc_nxt  = acc_r;
    rs_nxt   = rs_r;
    st_nxt   = st_r;
    so_nxt   = so_r;
    uk_nxt   = uk_r;
    k_nxt    = k_r;
    rd_nxt   = rd_r;
    push      = 1'b0;
    push_slot = ra;
    ov_nxt    = ov_r;
    ost_nxt   = ost_r;
    oslot_nxt = oslot_r;
    ofire_nxt = ofire_r;
    oev_nxt   = oev_r;
    otgt_nxt  = otgt_r;
    oq_nxt    = oq_r;
    olast_nxt = olast_r;

    case (cmd)
      C_LOAD: begin
        req_nxt  = req_t'(in_ch.req_type);
        s_nxt    = in_ch.slot[SLOT_W-1:0];
        d_nxt    = in_ch.delay_ticks[DELAY_BITS-1:0];
        keep_nxt = in_ch.keep_delay;
        evi_nxt  = in_ch.event_value;
        opti_nxt = in_ch.options;
        st_nxt   = ST_OK;
        so_nxt   = '0;
        k_nxt    = '0;
        rd_nxt   = '0;
      end
      C_ALLOC: begin
        if (ptr_ok(fh_r)) begin
          so_nxt       = ra;
          fh_nxt       = link_rd;
          link_nxt[ra] = NIL;
          kind_nxt[ra] = K_IDLE;
          used_nxt     = used_r + 1'b1;
        end else begin
          st_nxt = ST_NOFREE;
        end
      end
      C_RETURN: begin
        if (kind_r[s_r] == K_IDLE) begin
          link_nxt[s_r] = fh_r;
          fh_nxt        = {1'b0, s_r};
          kind_nxt[s_r] = K_FREE;
          if (used_r != '0) used_nxt = used_r - 1'b1;
        end
      end
      C_REL_LOCK: begin
        if (req_r == REQ_RELEASE) opt_nxt[s_r][OPT_LOCK_BIT] = 1'b0;
      end
      C_RS_PREP: begin
        if (keep_r) d_nxt = per_rd;
      end
      C_SET_ST2: st_nxt = ST_NOTRUN;
      C_SET_ST3: st_nxt = ST_ZERO;
      C_FIND_INIT: begin
        uk_nxt  = kind_r[s_r];
        cur_nxt = (kind_r[s_r] == K_ONE) ? oh_r : ph_r;
        prv_nxt = NIL;
      end
      C_FIND_STEP: begin
        prv_nxt = cur_r;
        cur_nxt = link_rd;
      end
      C_UNL_A: begin
        nx_nxt = link_rd;
        rs_nxt = rem_rd;
      end
      C_UNL_B: begin
        if (ptr_ok(prv_r)) begin
          link_nxt[prv_r[SLOT_W-1:0]] = nx_r;
        end else if (uk_r == K_ONE) begin
          oh_nxt = nx_r;
        end else begin
          ph_nxt = nx_r;
        end
        if (uk_r == K_ONE && ptr_ok(nx_r)) rem_nxt[ra] = rem_rd + rs_r;
        link_nxt[s_r] = NIL;
        kind_nxt[s_r] = K_IDLE;
      end
      C_STOP_FIN: begin
        if (!opt_rd[OPT_LOCK_BIT]) begin
          link_nxt[s_r] = fh_r;
          fh_nxt        = {1'b0, s_r};
          kind_nxt[s_r] = K_FREE;
          if (used_r != '0) used_nxt = used_r - 1'b1;
        end
      end
      C_STORE: begin
        per_nxt[s_r] = d_r;
        if (req_r == REQ_START) begin
          ev_nxt[s_r]  = evi_r;
          opt_nxt[s_r] = opti_r;
        end
      end
      C_INS_INIT: begin
        acc_nxt = d_r;
        prv_nxt = NIL;
        cur_nxt = oh_r;
        if (opt_rd[OPT_PER_BIT]) begin
          link_nxt[s_r] = ph_r;
          ph_nxt        = {1'b0, s_r};
          rem_nxt[s_r]  = d_r;
          kind_nxt[s_r] = K_PER;
        end
      end
      C_INS_WALK: begin
        if (ptr_ok(cur_r) && rem_rd < acc_r) begin
          acc_nxt = acc_r - rem_rd;
          prv_nxt = cur_r;
          cur_nxt = link_rd;
        end else begin
          if (ptr_ok(cur_r)) rem_nxt[ra] = rem_rd - acc_r;
          link_nxt[s_r] = cur_r;
          if (ptr_ok(prv_r)) begin
            link_nxt[prv_r[SLOT_W-1:0]] = {1'b0, s_r};
          end else begin
            oh_nxt = {1'b0, s_r};
          end
          rem_nxt[s_r]  = acc_r;
          kind_nxt[s_r] = K_ONE;
        end
      end
      C_TK_DEC: begin
        if (ptr_ok(oh_r)) rem_nxt[ra] = r_dec;
      end
      C_TK_OS: begin
        if (ptr_ok(oh_r) && rem_rd == '0 && k_room) begin
          push   = 1'b1;
          oh_nxt = link_rd;
          if (!opt_rd[OPT_LOCK_BIT]) begin
            link_nxt[ra] = fh_r;
            fh_nxt       = raddr;
            kind_nxt[ra] = K_FREE;
            if (used_r != '0) used_nxt = used_r - 1'b1;
          end else begin
            link_nxt[ra] = NIL;
            kind_nxt[ra] = K_IDLE;
          end
        end
      end
      C_TK_PINIT: cur_nxt = ph_r;
      C_TK_PER: begin
        if (ptr_ok(cur_r)) begin
          if (r_dec == '0 && k_room) begin
            push        = 1'b1;
            rem_nxt[ra] = per_rd;
          end else begin
            rem_nxt[ra] = r_dec;
          end
          cur_nxt = link_rd;
        end
      end
      C_OUT_LOAD: begin
        ov_nxt = 1'b1;
        if (k_r == '0) begin
          ost_nxt   = st_r;
          oslot_nxt = so_r;
          ofire_nxt = 1'b0;
          oev_nxt   = '0;
          otgt_nxt  = '0;
          oq_nxt    = 1'b0;
          olast_nxt = 1'b1;
        end else begin
          ost_nxt   = ST_OK;
          oslot_nxt = bslot_r[rd_r[SLOT_W-1:0]];
          ofire_nxt = 1'b1;
          oev_nxt   = bev_r[rd_r[SLOT_W-1:0]];
          otgt_nxt  = bopt_r[rd_r[SLOT_W-1:0]][3:0];
          oq_nxt    = bopt_r[rd_r[SLOT_W-1:0]][OPT_QUICK_BIT];
          olast_nxt = (rd_r + 1'b1) == k_r;
          rd_nxt    = rd_r + 1'b1;
        end
      end
      C_OUT_DONE: ov_nxt = 1'b0;
      default: ;
    endcase
    if (push) k_nxt = k_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        link_r[i] <= (i + 1 < NUM_SLOTS) ? PTR_W'(i + 1) : NIL;
        rem_r[i]  <= '0;
        per_r[i]  <= '0;
        ev_r[i]   <= '0;
        opt_r[i]  <= '0;
        kind_r[i] <= K_FREE;
      end
      oh_r   <= NIL;
      ph_r   <= NIL;
      fh_r   <= '0;
      used_r <= '0;
      ov_r   <= 1'b0;
      k_r    <= '0;
      rd_r   <= '0;
    end else begin
      link_r <= link_nxt;
      rem_r  <= rem_nxt;
      per_r  <= per_nxt;
      ev_r   <= ev_nxt;
      opt_r  <= opt_nxt;
      kind_r <= kind_nxt;
      oh_r   <= oh_nxt;
      ph_r   <= ph_nxt;
      fh_r   <= fh_nxt;
      used_r <= used_nxt;
      ov_r   <= ov_nxt;
      k_r    <= k_nxt;
      rd_r   <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    s_r     <= s_nxt;
    d_r     <= d_nxt;
    keep_r  <= keep_nxt;
    evi_r   <= evi_nxt;
    opti_r  <= opti_nxt;
    cur_r   <= cur_nxt;
    prv_r   <= prv_nxt;
    nx_r    <= nx_nxt;
    acc_r   <= acc_nxt;
    rs_r    <= rs_nxt;
    st_r    <= st_nxt;
    so_r    <= so_nxt;
    uk_r    <= uk_nxt;
    ost_r   <= ost_nxt;
    oslot_r <= oslot_nxt;
    ofire_r <= ofire_nxt;
    oev_r   <= oev_nxt;
    otgt_r  <= otgt_nxt;
    oq_r    <= oq_nxt;
    olast_r <= olast_nxt;
    if (push) begin
      bslot_r[k_r[SLOT_W-1:0]] <= push_slot;
      bev_r[k_r[SLOT_W-1:0]]   <= ev_rd;
      bopt_r[k_r[SLOT_W-1:0]]  <= opt_rd;
    end
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.status       = ost_r;
  assign out_ch.slot_out     = oslot_r;
  assign out_ch.fired        = ofire_r;
  assign out_ch.fired_event  = oev_r;
  assign out_ch.fired_target = otgt_r;
  assign out_ch.fired_quick  = oq_r;
  assign out_ch.used_count   = used_r;
  assign out_ch.last         = olast_r;

  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(NUM_SLOTS))
    else $error("allocated slot count out of range");

  a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && ofire_r |-> ost_r == ST_OK)
    else $error("expiry result with nonzero status");

  a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= CNT_W'(MAXRES) && rd_r <= k_r)
    else $error("result buffer index out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ch.ready |=> $stable(used_r) && $stable(oslot_r))
    else $error("stalled result changed");

endmodule

// File: rtl/core/stdl_ctrl.sv
module stdl_ctrl import stdl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output cmd_t     cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = C_NOP;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd       = C_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_RESP;
        case (stat.req)
          REQ_ALLOC:  cmd = C_ALLOC;
          REQ_RETURN: cmd = C_RETURN;
          REQ_START: begin
            if (stat.d_zero) begin
              cmd = C_SET_ST3;
            end else if (stat.kind_s == K_FREE) begin
              cmd = C_SET_ST2;
            end else if (stat.kind_s == K_IDLE) begin
              cmd       = C_STORE;
              state_nxt = S_INS_INIT;
            end else begin
              cmd       = C_FIND_INIT;
              state_nxt = S_FIND;
            end
          end
          REQ_STOP, REQ_RELEASE: begin
            cmd       = C_REL_LOCK;
            state_nxt = S_STOPCHK;
          end
          REQ_RESTART: begin
            if (stat.kind_s == K_FREE) begin
              cmd = C_SET_ST2;
            end else begin
              cmd       = C_RS_PREP;
              state_nxt = S_RSCHK;
            end
          end
          REQ_TICK: begin
            cmd       = C_TK_DEC;
            state_nxt = S_TK_OS;
          end
          default: ;
        endcase
      end
      S_STOPCHK: begin
        if (stat.kind_s == K_ONE || stat.kind_s == K_PER) begin
          cmd       = C_FIND_INIT;
          state_nxt = S_FIND;
        end else begin
          cmd       = C_SET_ST2;
          state_nxt = S_RESP;
        end
      end
      S_RSCHK: begin
        if (stat.d_zero) begin
          cmd       = C_SET_ST3;
          state_nxt = S_RESP;
        end else if (stat.kind_s == K_IDLE) begin
          cmd       = C_STORE;
          state_nxt = S_INS_INIT;
        end else begin
          cmd       = C_FIND_INIT;
          state_nxt = S_FIND;
        end
      end
      S_FIND: begin
        if (stat.found) begin
          cmd       = C_UNL_A;
          state_nxt = S_UNL_B;
        end else begin
          cmd = C_FIND_STEP;
        end
      end
      S_UNL_B: begin
        cmd       = C_UNL_B;
        state_nxt = S_AFTER_UNL;
      end
      S_AFTER_UNL: begin
        if (stat.req == REQ_START || stat.req == REQ_RESTART) begin
          cmd       = C_STORE;
          state_nxt = S_INS_INIT;
        end else begin
          cmd       = C_STOP_FIN;
          state_nxt = S_RESP;
        end
      end
      S_INS_INIT: begin
        cmd       = C_INS_INIT;
        state_nxt = stat.per_s ? S_RESP : S_INS_WALK;
      end
      S_INS_WALK: begin
        cmd = C_INS_WALK;
        if (!stat.walk_go) state_nxt = S_RESP;
      end
      S_TK_OS: begin
        cmd = C_TK_OS;
        if (!stat.os_go) state_nxt = S_TK_PINIT;
      end
      S_TK_PINIT: begin
        cmd       = C_TK_PINIT;
        state_nxt = S_TK_PER;
      end
      S_TK_PER: begin
        cmd = C_TK_PER;
        if (!stat.cur_ok) state_nxt = S_RESP;
      end
      S_RESP: begin
        cmd       = C_OUT_LOAD;
        state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (stat.out_fire) begin
          if (stat.more) begin
            cmd = C_OUT_LOAD;
          end else begin
            cmd       = C_OUT_DONE;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: rtl/core/software_timer_delta_list.sv
// Timer slot manager for sixteen software timers, kept as a free list, a
// deadline-sorted one-shot delta list and a list of periodic timers.
// Requests arrive as transactions on in_ch (valid/ready); each yields one or
// more result transactions on out_ch, the final one marked by last. A tick
// yields one result per expired timer, or a single plain result.
// One request is handled at a time: in_ch.ready is high only while the block
// is idle. Allocate and return pass from dispatch straight to the result;
// start, stop and restart are lengthened by the list walks that locate the
// predecessor and the insertion point, one list entry per cycle. A tick walks
// the expired one-shots, then the periodic timers, one entry a cycle.
// Further results of a tick follow one per cycle as out_ch accepts them.
// A stall on out_ch holds the current result and keeps in_ch closed until the
// final result is taken. A synchronous low rst_n restores all slots to the
// free list, clears both timer lists and zeroes the allocated count; no
// clearing pass is needed.
module software_timer_delta_list import stdl_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  stdl_in_if.sink    in_ch,
  stdl_out_if.source out_ch
);

  dp_stat_t stat;
  cmd_t     cmd;

  stdl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  stdl_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .stat   (stat),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
